// File: rtl/pcr_pkg.sv
`default_nettype none

package pcr_pkg;

    localparam int ChanW = 16;

    typedef enum logic [1:0] {
        RED_AVG  = 2'd0,
        RED_MIN  = 2'd1,
        RED_MAX  = 2'd2,
        RED_TERR = 2'd3
    } t_reduce_mode;

    typedef enum logic [1:0] {
        ALPHA_MUL  = 2'd0,
        ALPHA_ADD  = 2'd1,
        ALPHA_SUB  = 2'd2,
        ALPHA_NONE = 2'd3
    } t_alpha_mode;

    // configuration register indexes
    localparam logic [7:0] CFG_CHANNEL_COUNT = 8'd0;
    localparam logic [7:0] CFG_WIDE_CHANNELS = 8'd1;
    localparam logic [7:0] CFG_REDUCE_MODE   = 8'd2;
    localparam logic [7:0] CFG_ALPHA_MODE    = 8'd3;
    localparam logic [7:0] CFG_CHANNEL_MASK  = 8'd4;

    localparam logic [2:0] FOUR_CHANNELS = 3'd4;

    // sum / 3 as (sum * ceil(2^19 / 3)) >> 19, exact for sums below 2^19
    localparam logic [17:0] AVG_RECIP_3 = 18'd174763;
    localparam int          AvgShift    = 19;

    // terrarium offset of 32768 in 1/256 units, and the point below which
    // the truncated value turns negative
    localparam logic [32:0] TERR_OFFSET    = 33'd8388608;
    localparam logic [32:0] TERR_NEG_LIMIT = 33'd8388353;
    localparam logic [24:0] TERR_BIAS      = 25'd32768;

endpackage

`default_nettype wire

// File: rtl/pixel_channel_reduce.sv
// Reduces one pixel of 2 or 4 unsigned channels (8 or 16 bits each) to a single channel
// value: average, minimum or maximum of the active R/G/B channels, or the terrarium
// elevation decode R*256+G+B/256-32768, followed by an optional alpha multiply,
// saturating add or saturating subtract. The datapath is a seven-stage pipeline that
// takes one pixel per clock unless stalled; each result is presented from the output
// register and leaves when the output is not stalled. The depth comes from the
// divide-by-three multiply of the average and the alpha multiply with its reciprocal
// divide-by-full-scale, each given stages of its own. A stalled output holds only the
// stages that are full, so empty stages still take new pixels. Configuration writes
// are always ready and must be made while the pipeline is empty.
`default_nettype none

module pixel_channel_reduce
    import pcr_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,

    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [7:0]         i_cfg_index,
    input  wire logic [3:0]         i_cfg_data,

    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [ChanW-1:0]   i_red_value,
    input  wire logic [ChanW-1:0]   i_green_value,
    input  wire logic [ChanW-1:0]   i_blue_value,
    input  wire logic [ChanW-1:0]   i_alpha_value,

    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [ChanW-1:0]        o_reduced_value,
    output logic                    o_rgb_missing,
    output logic                    o_clipped
);

    // configuration registers
    logic [2:0]   r_channel_count;
    logic         r_wide;
    t_reduce_mode r_reduce_mode;
    t_alpha_mode  r_alpha_mode;
    logic [3:0]   r_channel_mask;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_count <= FOUR_CHANNELS;
            r_wide          <= 1'b0;
            r_reduce_mode   <= RED_AVG;
            r_alpha_mode    <= ALPHA_NONE;
            r_channel_mask  <= 4'hF;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_CHANNEL_COUNT: r_channel_count <= i_cfg_data[2:0];
                CFG_WIDE_CHANNELS: r_wide          <= i_cfg_data[0];
                CFG_REDUCE_MODE:   r_reduce_mode   <= t_reduce_mode'(i_cfg_data[1:0]);
                CFG_ALPHA_MODE:    r_alpha_mode    <= t_alpha_mode'(i_cfg_data[1:0]);
                CFG_CHANNEL_MASK:  r_channel_mask  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    logic [ChanW-1:0] full;
    logic             four;
    logic             act_r;
    logic             act_g;
    logic             act_b;

    assign full  = r_wide ? 16'hFFFF : 16'h00FF;
    assign four  = (r_channel_count == FOUR_CHANNELS);
    assign act_r = r_channel_mask[0];
    assign act_g = r_channel_mask[1];
    assign act_b = r_channel_mask[2] && four;

    // stage valid bits and per-stage advance
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7;
    logic en1, en2, en3, en4, en5, en6, en7;

    assign en7 = !r_v7 || !i_stall;
    assign en6 = !r_v6 || en7;
    assign en5 = !r_v5 || en6;
    assign en4 = !r_v4 || en5;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;

    assign o_stall = !en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
            if (en5) r_v5 <= r_v4;
            if (en6) r_v6 <= r_v5;
            if (en7) r_v7 <= r_v6;
        end
    end

    // stage 1: samples cut to the channel width
    logic [ChanW-1:0] r1_r, r1_g, r1_b, r1_a;

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_r <= i_red_value   & full;
            r1_g <= i_green_value & full;
            r1_b <= i_blue_value  & full;
            r1_a <= i_alpha_value & full;
        end
    end

    // stage 2: sum, count, min, max and the terrarium word
    logic [17:0]      n_sum;
    logic [1:0]       n_cnt;
    logic [ChanW-1:0] n_mn;
    logic [ChanW-1:0] n_mx;
    logic [32:0]      n_y;

    always_comb begin
        n_sum = 18'd0;
        n_cnt = 2'd0;
        n_mn  = full;
        n_mx  = '0;
        if (act_r) begin
            n_sum = n_sum + {2'b00, r1_r};
            n_cnt = n_cnt + 2'd1;
            if (r1_r < n_mn) n_mn = r1_r;
            if (r1_r > n_mx) n_mx = r1_r;
        end
        if (act_g) begin
            n_sum = n_sum + {2'b00, r1_g};
            n_cnt = n_cnt + 2'd1;
            if (r1_g < n_mn) n_mn = r1_g;
            if (r1_g > n_mx) n_mx = r1_g;
        end
        if (act_b) begin
            n_sum = n_sum + {2'b00, r1_b};
            n_cnt = n_cnt + 2'd1;
            if (r1_b < n_mn) n_mn = r1_b;
            if (r1_b > n_mx) n_mx = r1_b;
        end
        n_y = {1'b0, r1_r, 16'h0000} + {9'd0, r1_g, 8'h00} + {17'd0, r1_b};
    end

    logic [17:0]      r2_sum;
    logic [1:0]       r2_cnt;
    logic [ChanW-1:0] r2_mn, r2_mx, r2_a;
    logic [32:0]      r2_y;

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r2_sum <= n_sum;
            r2_cnt <= n_cnt;
            r2_mn  <= n_mn;
            r2_mx  <= n_mx;
            r2_y   <= n_y;
            r2_a   <= r1_a;
        end
    end

    // stage 3: divide-by-three product and terrarium saturation
    logic [35:0]      n_prod;
    logic [24:0]      n_t;
    logic [ChanW-1:0] n_terr;
    logic             n_terr_clip;

    always_comb begin
        n_prod      = r2_sum * AVG_RECIP_3;
        n_t         = r2_y[32:8] - TERR_BIAS;
        n_terr      = '0;
        n_terr_clip = 1'b0;
        if (r2_y < TERR_NEG_LIMIT) begin
            n_terr_clip = 1'b1;
        end else if (r2_y < TERR_OFFSET) begin
            // between -1 and 0 truncates to zero without clipping
            n_terr = '0;
        end else if (n_t > {9'd0, full}) begin
            n_terr      = full;
            n_terr_clip = 1'b1;
        end else begin
            n_terr = n_t[ChanW-1:0];
        end
    end

    logic [17:0]      r3_sum;
    logic [1:0]       r3_cnt;
    logic [35:0]      r3_prod;
    logic [ChanW-1:0] r3_mn, r3_mx, r3_terr, r3_a;
    logic             r3_terr_clip;

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r3_sum       <= r2_sum;
            r3_cnt       <= r2_cnt;
            r3_prod      <= n_prod;
            r3_mn        <= r2_mn;
            r3_mx        <= r2_mx;
            r3_terr      <= n_terr;
            r3_terr_clip <= n_terr_clip;
            r3_a         <= r2_a;
        end
    end

    // stage 4: pick the reduction
    logic [ChanW-1:0] n_avg;
    logic [ChanW-1:0] n_val4;
    logic             n_clip4;
    logic             n_missing;
    logic             n_do_alpha;

    always_comb begin
        unique case (r3_cnt)
            2'd0:    n_avg = '0;
            2'd1:    n_avg = r3_sum[ChanW-1:0];
            2'd2:    n_avg = r3_sum[ChanW:1];
            default: n_avg = r3_prod[AvgShift+ChanW-1:AvgShift];
        endcase
        n_missing = 1'b0;
        n_clip4   = 1'b0;
        unique case (r_reduce_mode)
            RED_AVG: n_val4 = n_avg;
            RED_MIN: n_val4 = r3_mn;
            RED_MAX: n_val4 = r3_mx;
            default: begin
                if (!four || r_channel_mask[2:0] != 3'b111) begin
                    n_missing = 1'b1;
                    n_val4    = '0;
                end else begin
                    n_val4  = r3_terr;
                    n_clip4 = r3_terr_clip;
                end
            end
        endcase
        n_do_alpha = !n_missing && four && r_channel_mask[3] && (r_alpha_mode != ALPHA_NONE);
    end

    logic [ChanW-1:0] r4_val, r4_a;
    logic             r4_clip, r4_missing, r4_do_alpha;

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r4_val      <= n_val4;
            r4_a        <= r3_a;
            r4_clip     <= n_clip4;
            r4_missing  <= n_missing;
            r4_do_alpha <= n_do_alpha;
        end
    end

    // stage 5: alpha product, saturating add and subtract
    logic [31:0]      n_p;
    logic [ChanW:0]   n_add;
    logic [ChanW-1:0] n_val5;
    logic             n_clip5;
    logic             n_mul;

    always_comb begin
        n_p     = r4_val * r4_a;
        n_add   = {1'b0, r4_val} + {1'b0, r4_a};
        n_val5  = r4_val;
        n_clip5 = r4_clip;
        n_mul   = 1'b0;
        if (r4_do_alpha) begin
            unique case (r_alpha_mode)
                ALPHA_MUL: n_mul = 1'b1;
                ALPHA_ADD: begin
                    if (n_add > {1'b0, full}) begin
                        n_val5  = full;
                        n_clip5 = 1'b1;
                    end else begin
                        n_val5 = n_add[ChanW-1:0];
                    end
                end
                ALPHA_SUB: begin
                    if (r4_a > r4_val) begin
                        n_val5  = '0;
                        n_clip5 = 1'b1;
                    end else begin
                        n_val5 = r4_val - r4_a;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    logic [31:0]      r5_p;
    logic [ChanW-1:0] r5_val;
    logic             r5_clip, r5_missing, r5_mul;

    always_ff @(posedge i_clk) begin
        if (en5) begin
            r5_p       <= n_p;
            r5_val     <= n_val5;
            r5_clip    <= n_clip5;
            r5_missing <= r4_missing;
            r5_mul     <= n_mul;
        end
    end

    // stage 6: quotient estimate for p / (2^k - 1), low by at most one
    logic [32:0] n_qsum;
    logic [16:0] n_q;

    always_comb begin
        if (r_wide) begin
            n_qsum = {1'b0, r5_p} + {17'd0, r5_p[31:16]};
            n_q    = n_qsum[32:16];
        end else begin
            n_qsum = {1'b0, r5_p} + {9'd0, r5_p[31:8]};
            n_q    = {8'd0, n_qsum[16:8]};
        end
    end

    logic [31:0]      r6_p;
    logic [16:0]      r6_q;
    logic [ChanW-1:0] r6_val;
    logic             r6_clip, r6_missing, r6_mul;

    always_ff @(posedge i_clk) begin
        if (en6) begin
            r6_p       <= r5_p;
            r6_q       <= n_q;
            r6_val     <= r5_val;
            r6_clip    <= r5_clip;
            r6_missing <= r5_missing;
            r6_mul     <= r5_mul;
        end
    end

    // stage 7: remainder check and output register
    logic [33:0]      n_qd;
    logic [33:0]      n_rem;
    logic [16:0]      n_qf;
    logic [ChanW-1:0] n_out;

    always_comb begin
        // q * (2^k - 1) as a shift and subtract
        if (r_wide) begin
            n_qd = {1'b0, r6_q, 16'd0} - {17'd0, r6_q};
        end else begin
            n_qd = {9'd0, r6_q, 8'd0} - {17'd0, r6_q};
        end
        n_rem = {2'b00, r6_p} - n_qd;
        n_qf  = (n_rem >= {18'd0, full}) ? r6_q + 17'd1 : r6_q;
        n_out = r6_mul ? n_qf[ChanW-1:0] : r6_val;
    end

    logic [ChanW-1:0] r7_val;
    logic             r7_clip, r7_missing;

    always_ff @(posedge i_clk) begin
        if (en7) begin
            r7_val     <= n_out;
            r7_clip    <= r6_clip;
            r7_missing <= r6_missing;
        end
    end

    assign o_valid         = r_v7;
    assign o_reduced_value = r7_val;
    assign o_rgb_missing   = r7_missing;
    assign o_clipped       = r7_clip;

endmodule

`default_nettype wire
